// ===== rtl/core/bdpe_pkg.sv =====
package bdpe_pkg;

  localparam int unsigned RUN_CLOSE_DEF = 8;
  localparam logic [31:0] CLIP_HEADER   = 32'd8;  // two 32-bit words per clip

  typedef enum logic [1:0] {
    CMD_COMPARE = 2'd0,
    CMD_TAIL    = 2'd1,
    CMD_END     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  // Records of one item, apart from the data bytes
  typedef struct packed {
    logic        start;
    logic [31:0] start_val;
    logic        close;
    logic [31:0] close_val;
    logic        fin;
    logic [31:0] fin_val;
    logic        need;
  } desc_ctl_t;

endpackage

// ===== rtl/core/bdpe_core.sv =====
module bdpe_core #(
  parameter int unsigned RUN_CLOSE = 8,
  parameter int unsigned CntW      = 4,
  parameter int unsigned IdxW      = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    new_byte_i,
  input  logic [7:0]                    old_byte_i,
  input  logic                          new_ends_i,
  input  logic                          lengths_differ_i,
  output logic                          has_res_o,
  output bdpe_pkg::desc_ctl_t           ctl_o,
  output logic [CntW-1:0]               cnt_o,
  output logic [RUN_CLOSE-1:0][7:0]     data_o
);
  import bdpe_pkg::*;

  logic                      open_q, open_d;
  logic [31:0]               skip_q, skip_d;
  logic [31:0]               commit_q, commit_d;  // clip bytes already flushed
  logic [CntW-1:0]           pc_q, pc_d;
  logic [31:0]               total_q, total_d;
  logic [RUN_CLOSE-1:0][7:0] buf_q;

  logic                      differ;
  logic [CntW-1:0]           pc0, pc1, pc_a;
  logic [31:0]               commit0, commit_a;
  logic [IdxW-1:0]           idx;
  logic                      do_close;
  logic                      buf_we;
  logic [RUN_CLOSE-1:0][7:0] data_next;

  assign differ  = (new_byte_i != old_byte_i);
  assign pc0     = open_q ? pc_q : '0;
  assign commit0 = open_q ? commit_q : '0;
  assign pc1     = pc0 + CntW'(1);
  assign idx     = pc0[IdxW-1:0];

  // pending bytes with the new byte placed behind them
  always_comb begin
    for (int i = 0; i < RUN_CLOSE; i++) begin
      data_next[i] = (IdxW'(i) == idx) ? new_byte_i : buf_q[i];
    end
  end

  assign data_o = data_next;

  always_comb begin
    open_d   = open_q;
    skip_d   = skip_q;
    commit_d = commit_q;
    pc_d     = pc_q;
    total_d  = total_q;
    ctl_o    = '0;
    cnt_o    = '0;
    buf_we   = 1'b0;
    pc_a     = pc1;
    commit_a = commit0;
    do_close = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_COMPARE: begin
        if (!open_q && !differ) begin
          skip_d = skip_q + 32'd1;
        end else begin
          ctl_o.start     = !open_q;
          ctl_o.start_val = skip_q;
          buf_we          = 1'b1;
          if (differ) begin
            cnt_o    = pc1;
            commit_a = commit0 + 32'(pc1);
            pc_a     = '0;
          end
          do_close = (pc_a >= CntW'(RUN_CLOSE)) || new_ends_i;
          if (do_close) begin
            // pending equal bytes are dropped and count as skipped
            ctl_o.close     = 1'b1;
            ctl_o.close_val = commit_a;
            total_d         = total_q + commit_a + CLIP_HEADER;
            skip_d          = 32'(pc_a);
            pc_d            = '0;
            commit_d        = '0;
            open_d          = 1'b0;
          end else begin
            open_d   = 1'b1;
            pc_d     = pc_a;
            commit_d = commit_a;
          end
        end
      end
      CMD_TAIL: begin
        ctl_o.start     = !open_q;
        ctl_o.start_val = skip_q;
        cnt_o           = pc1;
        commit_d        = commit0 + 32'(pc1);
        pc_d            = '0;
        open_d          = 1'b1;
      end
      CMD_END: begin
        ctl_o.fin = 1'b1;
        if (open_q) begin
          ctl_o.close     = 1'b1;
          ctl_o.close_val = commit_q;
          ctl_o.fin_val   = total_q + commit_q + CLIP_HEADER;
        end else begin
          ctl_o.fin_val   = total_q;
        end
        ctl_o.need = (ctl_o.fin_val != '0) || lengths_differ_i;
        open_d     = 1'b0;
        skip_d     = '0;
        commit_d   = '0;
        pc_d       = '0;
        total_d    = '0;
      end
      default: begin
      end
    endcase
  end

  assign has_res_o = ctl_o.start || ctl_o.close || ctl_o.fin || (cnt_o != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      skip_q   <= '0;
      commit_q <= '0;
      pc_q     <= '0;
      total_q  <= '0;
    end else if (go_i) begin
      open_q   <= open_d;
      skip_q   <= skip_d;
      commit_q <= commit_d;
      pc_q     <= pc_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && buf_we) begin
      buf_q <= data_next;
    end
  end

endmodule

// ===== rtl/core/bdpe_emit.sv =====
module bdpe_emit #(
  parameter int unsigned RUN_CLOSE = 8,
  parameter int unsigned CntW      = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  bdpe_pkg::desc_ctl_t       ctl_i,
  input  logic [CntW-1:0]           cnt_i,
  input  logic [RUN_CLOSE-1:0][7:0] data_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                record_kind_o,
  output logic [31:0]               record_value_o,
  output logic                      patch_needed_o,
  output logic                      last_of_run_o
);
  import bdpe_pkg::*;

  logic                      st_q, close_q, fin_q;
  logic [CntW-1:0]           cnt_q;
  logic [RUN_CLOSE-1:0][7:0] data_q, data_shift;
  logic [31:0]               start_val_q, close_val_q, fin_val_q;
  logic                      need_q;
  logic                      pop, rest;
  kind_e                     kind;

  assign out_valid_o = st_q || close_q || fin_q || (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    rest = 1'b0;
    kind = KIND_FINISH;
    priority if (st_q) begin
      kind = KIND_START;
      rest = (cnt_q != '0) || close_q || fin_q;
    end else if (cnt_q != '0) begin
      kind = KIND_DATA;
      rest = (cnt_q > CntW'(1)) || close_q || fin_q;
    end else if (close_q) begin
      kind = KIND_CLOSE;
      rest = fin_q;
    end else begin
      kind = KIND_FINISH;
    end
  end

  always_comb begin
    unique case (kind)
      KIND_START:  record_value_o = start_val_q;
      KIND_DATA:   record_value_o = {24'h0, data_q[0]};
      KIND_CLOSE:  record_value_o = close_val_q;
      KIND_FINISH: record_value_o = fin_val_q;
      default:     record_value_o = fin_val_q;
    endcase
  end

  always_comb begin
    data_shift = data_q;
    for (int i = 0; i < RUN_CLOSE - 1; i++) begin
      data_shift[i] = data_q[i + 1];
    end
  end

  assign record_kind_o  = kind;
  assign patch_needed_o = (kind == KIND_FINISH) && need_q;
  assign last_of_run_o  = !rest;
  assign free_o         = !out_valid_o || (pop && !rest);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= 1'b0;
      close_q <= 1'b0;
      fin_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      st_q    <= ctl_i.start;
      close_q <= ctl_i.close;
      fin_q   <= ctl_i.fin;
      cnt_q   <= cnt_i;
    end else if (pop) begin
      priority if (st_q) begin
        st_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end else if (close_q) begin
        close_q <= 1'b0;
      end else begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q      <= data_i;
      start_val_q <= ctl_i.start_val;
      close_val_q <= ctl_i.close_val;
      fin_val_q   <= ctl_i.fin_val;
      need_q      <= ctl_i.need;
    end else if (pop && !st_q && (cnt_q != '0)) begin
      data_q <= data_shift;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("item descriptor loaded over pending records");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !rest && !load_i) |=> !out_valid_o)
    else $error("records left after last of item");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RUN_CLOSE))
    else $error("data count exceeds buffer depth");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind == KIND_FINISH)) |-> last_of_run_o)
    else $error("finish record not last of its item");

endmodule

// ===== rtl/core/byte_delta_patch_encoder.sv =====
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_stall_o   command_i new_byte_i old_byte_i new_ends_i
//                                       lengths_differ_i
// out      out  out_valid_o/out_stall_i record_kind_o record_value_o patch_needed_o
//                                       last_of_run_o
//
// An item without records is never held for the output sequencer; one with records
// waits in the input register until the sequencer is free. The sequencer gives one
// record per cycle while out_stall_i is low; it is loaded from the input register.
// Reset clears the clip state and both stages; the byte buffer needs no clear.
// While the output stalls, input is taken if no item or a record-free item is held.
module byte_delta_patch_encoder #(
  parameter int unsigned RUN_CLOSE = bdpe_pkg::RUN_CLOSE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  new_byte_i,
  input  logic [7:0]  old_byte_i,
  input  logic        new_ends_i,
  input  logic        lengths_differ_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [31:0] record_value_o,
  output logic        patch_needed_o,
  output logic        last_of_run_o
);
  import bdpe_pkg::*;

  localparam int unsigned CntW = $clog2(RUN_CLOSE + 1);
  localparam int unsigned IdxW = (RUN_CLOSE > 1) ? $clog2(RUN_CLOSE) : 1;

  logic                      in_valid_q;
  logic [1:0]                command_q;
  logic [7:0]                new_byte_q, old_byte_q;
  logic                      new_ends_q, lengths_differ_q;
  logic                      take, proc, has_res, emit_free;
  desc_ctl_t                 ctl;
  logic [CntW-1:0]           cnt;
  logic [RUN_CLOSE-1:0][7:0] data;

  // items without records pass even while the output sequencer is busy
  assign proc       = in_valid_q && (emit_free || !has_res);
  assign in_stall_o = in_valid_q && !proc;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      command_q        <= command_i;
      new_byte_q       <= new_byte_i;
      old_byte_q       <= old_byte_i;
      new_ends_q       <= new_ends_i;
      lengths_differ_q <= lengths_differ_i;
    end
  end

  bdpe_core #(
    .RUN_CLOSE (RUN_CLOSE),
    .CntW      (CntW),
    .IdxW      (IdxW)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .go_i             (proc),
    .command_i        (command_q),
    .new_byte_i       (new_byte_q),
    .old_byte_i       (old_byte_q),
    .new_ends_i       (new_ends_q),
    .lengths_differ_i (lengths_differ_q),
    .has_res_o        (has_res),
    .ctl_o            (ctl),
    .cnt_o            (cnt),
    .data_o           (data)
  );

  bdpe_emit #(
    .RUN_CLOSE (RUN_CLOSE),
    .CntW      (CntW)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (proc && has_res),
    .ctl_i          (ctl),
    .cnt_i          (cnt),
    .data_i         (data),
    .free_o         (emit_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .record_value_o (record_value_o),
    .patch_needed_o (patch_needed_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ===== bench/tb_byte_delta_patch_encoder.sv =====
`timescale 1ns / 1ps

module tb_byte_delta_patch_encoder;
  import bdpe_pkg::*;

  localparam int unsigned RUN_CLOSE = RUN_CLOSE_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 46;
  localparam int unsigned MAX_REPORTS = 200;

  // How a stimulus row gets its expected records
  localparam int unsigned FORM_PREDICT = 0;
  localparam int unsigned FORM_NONE    = 1;
  localparam int unsigned FORM_ONE     = 2;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  new_b;
    logic [7:0]  old_b;
    logic        ends;
    logic        ldiff;
    int unsigned form;
    kind_e       tkind;
    logic [31:0] tval;
    logic        tneed;
  } byte_item_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] value;
    logic        need;
    logic        last;
  } patch_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_COMPARE;
  logic [7:0]  new_byte = 8'h00;
  logic [7:0]  old_byte = 8'h00;
  logic        new_ends = 1'b0;
  logic        lengths_differ = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [31:0] record_value;
  logic        patch_needed;
  logic        last_of_run;

  byte_delta_patch_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .new_byte_i       (new_byte),
    .old_byte_i       (old_byte),
    .new_ends_i       (new_ends),
    .lengths_differ_i (lengths_differ),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .record_kind_o    (record_kind),
    .record_value_o   (record_value),
    .patch_needed_o   (patch_needed),
    .last_of_run_o    (last_of_run)
  );

  always #5 clk_i = ~clk_i;

  // Encoder state mirror
  logic        clip_open;
  logic [31:0] skip_cnt;
  logic [31:0] clip_len;
  int unsigned pend_cnt;
  logic [7:0]  pend_q [RUN_CLOSE];
  logic [31:0] total_size;

  byte_item_t  stim_q[$];
  byte_item_t  cur_item;
  patch_rec_t  pred_recs[$];
  patch_rec_t  exp_recs[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned items_done = 0;
  int unsigned recs_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned finishes_seen = 0;
  int unsigned files_sent = 0;

  function automatic byte_item_t mk_row(logic [1:0] cmd, logic [7:0] nb, logic [7:0] ob,
                                        logic ends, logic ldiff, int unsigned form,
                                        kind_e tkind, logic [31:0] tval, logic tneed);
    byte_item_t it;
    it.cmd   = cmd;
    it.new_b = nb;
    it.old_b = ob;
    it.ends  = ends;
    it.ldiff = ldiff;
    it.form  = form;
    it.tkind = tkind;
    it.tval  = tval;
    it.tneed = tneed;
    return it;
  endfunction

  task automatic clear_state();
    clip_open  = 1'b0;
    skip_cnt   = '0;
    clip_len   = '0;
    pend_cnt   = 0;
    total_size = '0;
  endtask

  task automatic add_rec(kind_e kind, logic [31:0] value, logic need);
    patch_rec_t r;
    r.kind  = kind;
    r.value = value;
    r.need  = need;
    r.last  = 1'b0;
    pred_recs.push_back(r);
  endtask

  task automatic open_clip();
    add_rec(KIND_START, skip_cnt, 1'b0);
    clip_open = 1'b1;
    pend_cnt  = 0;
    clip_len  = '0;
  endtask

  task automatic flush_pend();
    for (int unsigned k = 0; k < pend_cnt; k++) add_rec(KIND_DATA, {24'd0, pend_q[k]}, 1'b0);
    pend_cnt = 0;
  endtask

  // Trailing equal bytes are dropped from the clip and become the next skip
  task automatic close_clip();
    clip_len = clip_len - pend_cnt;
    add_rec(KIND_CLOSE, clip_len, 1'b0);
    total_size = total_size + clip_len + CLIP_HEADER;
    skip_cnt   = pend_cnt;
    pend_cnt   = 0;
    clip_len   = '0;
    clip_open  = 1'b0;
  endtask

  task automatic encode_item(input byte_item_t it);
    logic        differ;
    logic [31:0] size;
    pred_recs.delete();
    case (it.cmd)
      CMD_COMPARE: begin
        differ = it.new_b != it.old_b;
        if (!clip_open && !differ) begin
          skip_cnt = skip_cnt + 1;
        end else begin
          if (!clip_open) open_clip();
          if (pend_cnt < RUN_CLOSE) begin
            pend_q[pend_cnt] = it.new_b;
            pend_cnt++;
          end
          clip_len = clip_len + 1;
          if (differ) flush_pend();
          if (pend_cnt >= RUN_CLOSE || it.ends) close_clip();
        end
      end
      CMD_TAIL: begin
        if (!clip_open) open_clip();
        else flush_pend();
        add_rec(KIND_DATA, {24'd0, it.new_b}, 1'b0);
        clip_len = clip_len + 1;
      end
      CMD_END: begin
        if (clip_open) close_clip();
        size = total_size;
        add_rec(KIND_FINISH, size, (size != 0) || it.ldiff);
        clear_state();
      end
      default: begin
      end
    endcase
    if (pred_recs.size() > 0) pred_recs[pred_recs.size() - 1].last = 1'b1;
  endtask

  // One file pair: runs of equal and differing bytes, an optional tail, then end.
  // Now and then the end is left out or random noise is slipped in.
  task automatic queue_file();
    int unsigned len;
    int unsigned shape;
    int unsigned tail;
    int unsigned pos;
    int unsigned run;
    bit          diff_run;
    logic [7:0]  nb;
    logic [7:0]  ob;
    len      = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
    shape    = $urandom_range(0, 2);  // same length, new longer, new shorter
    tail     = (shape == 1) ? $urandom_range(1, 4) : 0;
    diff_run = 1'($urandom_range(0, 1));
    pos      = 0;
    while (pos < len) begin
      run = diff_run ? $urandom_range(1, 3) : $urandom_range(1, 11);
      while (run > 0 && pos < len) begin
        nb = 8'($urandom_range(0, 255));
        ob = diff_run ? (nb ^ 8'($urandom_range(1, 255))) : nb;
        stim_q.push_back(mk_row(CMD_COMPARE, nb, ob, (pos == len - 1) && (shape != 1),
                                1'($urandom_range(0, 1)), FORM_PREDICT, KIND_START, '0,
                                1'b0));
        pos++;
        run--;
      end
      diff_run = !diff_run;
    end
    repeat (tail) begin
      stim_q.push_back(mk_row(CMD_TAIL, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              FORM_PREDICT, KIND_START, '0, 1'b0));
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        stim_q.push_back(mk_row(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), FORM_PREDICT, KIND_START, '0,
                                1'b0));
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      stim_q.push_back(mk_row(CMD_END, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), shape != 0,
                              FORM_PREDICT, KIND_START, '0, 1'b0));
    end
    files_sent++;
  endtask

  function automatic int unsigned counted(const ref byte_item_t q[$]);
    int unsigned n;
    n = 0;
    foreach (q[i]) if (q[i].cmd != CMD_UNUSED) n++;
    return n;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk_i) begin
    patch_rec_t e;
    patch_rec_t r;
    if (rst_ni) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);

      if (out_valid && !out_stall) begin
        recs_seen++;
        if (record_kind == KIND_START) starts_seen++;
        if (record_kind == KIND_FINISH) finishes_seen++;
        if (exp_recs.size() == 0) begin
          report("unexpected record kind", 32'(record_kind), 32'(record_kind));
        end else begin
          e = exp_recs.pop_front();
          if (record_kind != e.kind) report("record_kind", 32'(e.kind), 32'(record_kind));
          if (record_value != e.value) report("record_value", e.value, record_value);
          if (patch_needed != e.need) report("patch_needed", 32'(e.need), 32'(patch_needed));
          if (last_of_run != e.last) report("last_of_run", 32'(e.last), 32'(last_of_run));
        end
      end

      if (in_valid && !in_stall) begin
        encode_item(cur_item);
        if (cur_item.cmd != CMD_UNUSED) items_done++;
        if (cur_item.form == FORM_PREDICT) begin
          foreach (pred_recs[i]) exp_recs.push_back(pred_recs[i]);
        end else if (cur_item.form == FORM_ONE) begin
          r.kind  = cur_item.tkind;
          r.value = cur_item.tval;
          r.need  = cur_item.tneed;
          r.last  = 1'b1;
          exp_recs.push_back(r);
        end
      end

      if (!in_valid || !in_stall) begin
        if (stim_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_item       <= stim_q[0];
          command        <= stim_q[0].cmd;
          new_byte       <= stim_q[0].new_b;
          old_byte       <= stim_q[0].old_b;
          new_ends       <= stim_q[0].ends;
          lengths_differ <= stim_q[0].ldiff;
          in_valid       <= 1'b1;
          void'(stim_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles", cycle_cnt);
    $display("FAIL byte_delta_patch_encoder");
    $finish;
  end

  task automatic drain();
    while (stim_q.size() > 0 || in_valid || exp_recs.size() > 0) @(negedge clk_i);
    // an item with no records may still be in flight
    repeat (6) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase_items;
    clear_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows
    stim_q.push_back(mk_row(CMD_END, 8'h00, 8'h00, 1'b0, 1'b0, FORM_ONE, KIND_FINISH, '0, 1'b0));
    stim_q.push_back(mk_row(CMD_END, 8'hff, 8'hff, 1'b1, 1'b1, FORM_ONE, KIND_FINISH, '0, 1'b1));
    stim_q.push_back(mk_row(CMD_UNUSED, 8'hff, 8'h00, 1'b1, 1'b1, FORM_NONE, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'h00, 8'h00, 1'b0, 1'b1, FORM_NONE, KIND_START,
                            '0, 1'b0));
    // equal last byte with no clip open is only skipped
    stim_q.push_back(mk_row(CMD_COMPARE, 8'hff, 8'hff, 1'b1, 1'b0, FORM_NONE, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'hff, 8'h00, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'haa, 8'haa, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'h55, 8'hff, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'h12, 8'h12, 1'b1, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_TAIL, 8'h80, 8'h01, 1'b1, 1'b1, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    repeat (RUN_CLOSE - 1) begin
      stim_q.push_back(mk_row(CMD_COMPARE, 8'h3c, 8'h3c, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                              '0, 1'b0));
    end
    // full buffer flushed and the clip closed by the same item
    stim_q.push_back(mk_row(CMD_COMPARE, 8'h00, 8'hff, 1'b1, 1'b1, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_TAIL, 8'h7f, 8'h80, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_COMPARE, 8'h11, 8'h11, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_TAIL, 8'h00, 8'hff, 1'b1, 1'b1, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_END, 8'h5a, 8'ha5, 1'b1, 1'b0, FORM_PREDICT, KIND_START,
                            '0, 1'b0));
    stim_q.push_back(mk_row(CMD_UNUSED, 8'h00, 8'hff, 1'b0, 1'b0, FORM_NONE, KIND_START,
                            '0, 1'b0));
    drain();

    // Random files under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        queue_file();
        phase_items = counted(stim_q);
      end
      // close out any file left open so the next phase starts clean
      stim_q.push_back(mk_row(CMD_END, 8'h00, 8'h00, 1'b0, 1'b0, FORM_PREDICT, KIND_START,
                              '0, 1'b0));
      drain();
    end

    $display("Ran %0d items over %0d random files: %0d records checked, %0d clips opened,",
             items_done, files_sent, recs_seen, starts_seen);
    $display("%0d finish records, idling and stalling mixes from 0 to 51 percent.",
             finishes_seen);
    if (err_cnt == 0) begin
      $display("PASS byte_delta_patch_encoder");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL byte_delta_patch_encoder");
    end
    $finish;
  end

endmodule
